### src/playfair_digraph_cipher_macros.svh
// Assertion macros shared by the playfair digraph cipher RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### src/pf_pkg.sv
// Package for the playfair digraph cipher: letter codes, key square types,
// reset square and the square lookup functions. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pf_pkg;

    localparam int SIDE = 5;

    localparam logic [4:0] LETTER_I   = 5'd8;
    localparam logic [4:0] LETTER_J   = 5'd9;
    localparam logic [4:0] LETTER_X   = 5'd23;
    localparam logic [4:0] LETTER_MAX = 5'd25;

    // Configuration register indexes
    localparam logic [2:0] REG_DECRYPT = 3'd0;
    localparam logic [2:0] REG_ROW0    = 3'd1;
    localparam logic [2:0] REG_ROW4    = 3'd5;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] pos_idx_t;
    // Column k of a row sits at bits 5k
    typedef letter_t [SIDE-1:0] row_t;
    typedef row_t    [SIDE-1:0] square_t;

    localparam logic [24:0] ROW0_RST = 25'd4294688;
    localparam logic [24:0] ROW1_RST = 25'd10755269;
    localparam logic [24:0] ROW2_RST = 25'd16201099;
    localparam logic [24:0] ROW3_RST = 25'd21613104;
    localparam logic [24:0] ROW4_RST = 25'd27025109;

    typedef struct packed {
        logic    decrypt;
        square_t square;
    } cfg_t;

    typedef struct packed {
        logic    valid;
        letter_t a;
        letter_t b;
        logic    is_last;
    } pair_t;

    typedef struct packed {
        pos_idx_t row;
        pos_idx_t col;
    } pos_t;

    // First match in row-major order wins; no match gives row 0, column 0
    function automatic pos_t locate(square_t sq, letter_t ch);
        pos_t pos;
        pos = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[r][c] == ch) begin
                    pos.row = pos_idx_t'(r);
                    pos.col = pos_idx_t'(c);
                end
            end
        end
        return pos;
    endfunction

    // One place forward or backward, modulo the square side
    function automatic pos_idx_t step(pos_idx_t v, logic dec);
        pos_idx_t res;
        if (dec) begin
            res = (v == '0) ? pos_idx_t'(SIDE - 1) : v - pos_idx_t'(1);
        end
        else begin
            res = (v == pos_idx_t'(SIDE - 1)) ? '0 : v + pos_idx_t'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### src/pf_ifs.sv
// Channel interfaces for the playfair digraph cipher: plaintext letters,
// result letters and configuration writes. Depends on pf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pf_text_if;
    logic            valid;
    logic            ready;
    pf_pkg::letter_t letter;
    logic            end_of_text;

    modport source (output valid, output letter, output end_of_text, input ready);
    modport sink (input valid, input letter, input end_of_text, output ready);
endinterface

interface pf_result_if;
    logic            valid;
    logic            ready;
    pf_pkg::letter_t out_letter;
    logic            out_last;

    modport source (output valid, output out_letter, output out_last, input ready);
    modport sink (input valid, input out_letter, input out_last, output ready);
endinterface

interface pf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [24:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/pf_config.sv
// Configuration registers: mode bit and the five key square rows.
// Depends on pf_pkg and pf_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module pf_config (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pf_cfg_if.sink        cfg,
    output pf_pkg::cfg_t  conf
);

    logic            decrypt_reg;
    pf_pkg::square_t square_reg;
    logic            wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_reg   <= 1'b0;
            square_reg[0] <= pf_pkg::ROW0_RST;
            square_reg[1] <= pf_pkg::ROW1_RST;
            square_reg[2] <= pf_pkg::ROW2_RST;
            square_reg[3] <= pf_pkg::ROW3_RST;
            square_reg[4] <= pf_pkg::ROW4_RST;
        end
        else if (wr)
        begin
            if (cfg.index == pf_pkg::REG_DECRYPT)
            begin
                decrypt_reg <= cfg.data[0];
            end
            else if (cfg.index <= pf_pkg::REG_ROW4)
            begin
                // Row number is the index minus one; indexes past the list drop
                square_reg[cfg.index - pf_pkg::REG_ROW0] <= cfg.data;
            end
        end
    end

    assign conf.decrypt = decrypt_reg;
    assign conf.square  = square_reg;

endmodule

`default_nettype wire

### src/pf_pairer.sv
// Digraph former: folds j into i, holds an unpaired letter and queues up to
// two letter pairs per input transfer. Depends on pf_pkg and pf_text_if.
`timescale 1ns / 1ps
`default_nettype none
`include "playfair_digraph_cipher_macros.svh"

module pf_pairer (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pf_text_if.sink       text,
    input  wire logic     pair_take,
    output pf_pkg::pair_t pair
);

    logic            held_valid_reg, held_valid_next;
    pf_pkg::letter_t held_letter_reg, held_letter_next;
    logic            job_valid_reg;
    logic            job_two_reg;
    logic            job_ptr_reg;
    pf_pkg::letter_t a0_reg, b0_reg, a1_reg, b1_reg;
    pf_pkg::letter_t a0_next, b0_next, a1_next, b1_next;
    logic [1:0]      cnt_next;
    pf_pkg::letter_t ch;
    logic            accept;
    logic            job_done;

    assign ch       = (text.letter == pf_pkg::LETTER_J) ? pf_pkg::LETTER_I : text.letter;
    assign job_done = pair_take && pair.is_last;
    assign text.ready = !job_valid_reg || job_done;
    assign accept   = text.valid && text.ready;

    always_comb
    begin
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        cnt_next         = 2'd0;
        a0_next          = held_letter_reg;
        b0_next          = pf_pkg::LETTER_X;
        a1_next          = held_letter_reg;
        b1_next          = pf_pkg::LETTER_X;
        if (text.letter <= pf_pkg::LETTER_MAX)
        begin
            if (!held_valid_reg)
            begin
                held_valid_next  = 1'b1;
                held_letter_next = ch;
            end
            else if (held_letter_reg == ch)
            begin
                // Doubled letter: close with filler, keep the new one held
                cnt_next = 2'd1;
            end
            else
            begin
                b0_next         = ch;
                cnt_next        = 2'd1;
                held_valid_next = 1'b0;
            end
        end
        if (text.end_of_text && held_valid_next)
        begin
            if (cnt_next == 2'd0)
            begin
                a0_next = held_letter_next;
            end
            else
            begin
                a1_next = held_letter_next;
            end
            cnt_next        = cnt_next + 2'd1;
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg  <= 1'b0;
            held_letter_reg <= '0;
            job_valid_reg   <= 1'b0;
            job_two_reg     <= 1'b0;
            job_ptr_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_valid_reg  <= held_valid_next;
                held_letter_reg <= held_letter_next;
            end
            if (accept && cnt_next != 2'd0)
            begin
                job_valid_reg <= 1'b1;
                job_two_reg   <= cnt_next[1];
                job_ptr_reg   <= 1'b0;
            end
            else if (job_done)
            begin
                job_valid_reg <= 1'b0;
            end
            else if (pair_take)
            begin
                job_ptr_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a0_reg <= a0_next;
            b0_reg <= b0_next;
            a1_reg <= a1_next;
            b1_reg <= b1_next;
        end
    end

    assign pair.valid   = job_valid_reg;
    assign pair.a       = job_ptr_reg ? a1_reg : a0_reg;
    assign pair.b       = job_ptr_reg ? b1_reg : b0_reg;
    assign pair.is_last = !job_two_reg || job_ptr_reg;

    `ASSERT_IMP(a_stall_busy, clk, rst_n, !text.ready, job_valid_reg)
    `ASSERT_IMP(a_ptr_two, clk, rst_n, job_valid_reg && job_ptr_reg, job_two_reg)
    `ASSERT_NXT(a_drain, clk, rst_n, job_done && !accept, !job_valid_reg)
    `ASSERT_NXT(a_eot_clear, clk, rst_n, accept && text.end_of_text, !held_valid_reg)

endmodule

`default_nettype wire

### src/pf_cipher.sv
// Key square lookup for one digraph and the result letter register that
// sends the two letters in turn. Depends on pf_pkg and pf_result_if.
`timescale 1ns / 1ps
`default_nettype none

module pf_cipher (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire pf_pkg::cfg_t  conf,
    input  wire pf_pkg::pair_t pair,
    output logic          pair_take,
    pf_result_if.source   result
);

    logic            pr_valid_reg;
    logic            pr_idx_reg;
    logic            pr_last_reg;
    pf_pkg::letter_t oa_reg, ob_reg;
    pf_pkg::letter_t oa_next, ob_next;
    pf_pkg::pos_t    pa, pb;
    logic            pr_free;
    logic            sent;

    assign pa = pf_pkg::locate(conf.square, pair.a);
    assign pb = pf_pkg::locate(conf.square, pair.b);

    always_comb
    begin
        if (pa.row == pb.row)
        begin
            oa_next = conf.square[pa.row][pf_pkg::step(pa.col, conf.decrypt)];
            ob_next = conf.square[pb.row][pf_pkg::step(pb.col, conf.decrypt)];
        end
        else if (pa.col == pb.col)
        begin
            oa_next = conf.square[pf_pkg::step(pa.row, conf.decrypt)][pa.col];
            ob_next = conf.square[pf_pkg::step(pb.row, conf.decrypt)][pb.col];
        end
        else
        begin
            // Rectangle: swap columns
            oa_next = conf.square[pa.row][pb.col];
            ob_next = conf.square[pb.row][pa.col];
        end
    end

    assign sent      = result.valid && result.ready;
    assign pr_free   = !pr_valid_reg || (sent && pr_idx_reg);
    assign pair_take = pair.valid && pr_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg <= 1'b0;
            pr_idx_reg   <= 1'b0;
        end
        else if (pair_take)
        begin
            pr_valid_reg <= 1'b1;
            pr_idx_reg   <= 1'b0;
        end
        else if (sent)
        begin
            // Advance to the second letter, or drop the finished pair
            pr_idx_reg   <= 1'b1;
            pr_valid_reg <= !pr_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_take)
        begin
            oa_reg      <= oa_next;
            ob_reg      <= ob_next;
            pr_last_reg <= pair.is_last;
        end
    end

    assign result.valid      = pr_valid_reg;
    assign result.out_letter = pr_idx_reg ? ob_reg : oa_reg;
    assign result.out_last   = pr_idx_reg && pr_last_reg;

endmodule

`default_nettype wire

### src/playfair_digraph_cipher.sv
// Playfair digraph cipher top level: configuration registers, digraph
// former and key square lookup. Depends on pf_pkg, pf_ifs and submodules.
//
//  channel | modport | payload                     | transfer when
//  --------+---------+-----------------------------+-------------------
//  text    | sink    | letter, end_of_text         | valid && ready
//  cipher  | source  | out_letter, out_last        | valid && ready
//  cfg     | sink    | index (0 mode, 1..5 rows)   | valid && ready
//
// A letter is taken every cycle while no pair waits or the last one is taken.
// Each digraph occupies the result register for its two letters, one letter
// a cycle while cipher is ready. The first result letter passes the pairer's
// pair registers, then the result register. Reset drops the held letter and
// loads the plain a..z square (no j) in encrypt mode. cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_cipher (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pf_text_if.sink     text,
    pf_result_if.source cipher,
    pf_cfg_if.sink      cfg
);

    pf_pkg::cfg_t  conf;
    pf_pkg::pair_t pair;
    logic          pair_take;

    pf_config u_config (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .conf  (conf)
    );

    pf_pairer u_pairer (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .pair_take (pair_take),
        .pair      (pair)
    );

    pf_cipher u_cipher (
        .clk       (clk),
        .rst_n     (rst_n),
        .conf      (conf),
        .pair      (pair),
        .pair_take (pair_take),
        .result    (cipher)
    );

endmodule

`default_nettype wire
